### sv/morse_code_keyer_macros.svh
// Assertion shorthands shared by the keyer modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MCK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/mck_pkg.sv
package mck_pkg;

  // Longest code that is keyed; longer codes are cut to this many elements.
  localparam int MAX_ELEMENTS = 7;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);

  // Segment lengths in time units.
  localparam logic [2:0] UNITS_DIT      = 3'd1;
  localparam logic [2:0] UNITS_DAH      = 3'd3;
  localparam logic [2:0] UNITS_ELEM_GAP = 3'd1;
  localparam logic [2:0] UNITS_CHAR_GAP = 3'd3;
  localparam logic [2:0] UNITS_WORD_GAP = 3'd7;

  // Characters with special handling.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MARK_PINS  = 2'd0;
  localparam logic [1:0] REG_SPACE_PINS = 2'd1;
  localparam logic [1:0] REG_UNIT_MS    = 2'd2;

  // Register reset values.
  localparam logic [7:0]  MARK_PINS_RST  = 8'd1;
  localparam logic [7:0]  SPACE_PINS_RST = 8'd0;
  localparam logic [15:0] UNIT_MS_RST    = 16'd100;

  typedef struct packed {
    logic [7:0]  mark_pins;
    logic [7:0]  space_pins;
    logic [15:0] unit_ms;
  } cfg_t;

  // Code table entry: element count and one bit per element (1 = dah),
  // first element in bit 0.
  typedef struct packed {
    logic [3:0] len;
    logic [7:0] dah;
  } morse_code_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    logic       emit;
    logic       mark;
    logic [2:0] units;
    logic       run_end;
    logic       advance;
  } mck_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_space;
    logic known;
    logic elem_last;
    logic dah;
    logic final_char;
    logic out_free;
  } mck_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MARK,
    ST_ELEM_GAP,
    ST_WORD_GAP,
    ST_CHAR_GAP
  } mck_state_e;

  // Fixed ITU table with the extra Latin-1 letters and punctuation.
  // A length of zero marks a character that has no code.
  function automatic morse_code_t mck_lookup(input logic [7:0] c);
    morse_code_t r;
    r = '0;
    case (c)
      8'h61: r = '{len: 4'd2, dah: 8'b00000010};
      8'hE4: r = '{len: 4'd4, dah: 8'b00001010};
      8'h62: r = '{len: 4'd4, dah: 8'b00000001};
      8'h63: r = '{len: 4'd4, dah: 8'b00000101};
      8'h64: r = '{len: 4'd3, dah: 8'b00000001};
      8'h65: r = '{len: 4'd1, dah: 8'b00000000};
      8'h66: r = '{len: 4'd4, dah: 8'b00000100};
      8'h67: r = '{len: 4'd3, dah: 8'b00000011};
      8'h68: r = '{len: 4'd4, dah: 8'b00000000};
      8'h69: r = '{len: 4'd2, dah: 8'b00000000};
      8'h6A: r = '{len: 4'd4, dah: 8'b00001110};
      8'h6B: r = '{len: 4'd3, dah: 8'b00000101};
      8'h6C: r = '{len: 4'd4, dah: 8'b00000010};
      8'h6D: r = '{len: 4'd2, dah: 8'b00000011};
      8'h6E: r = '{len: 4'd2, dah: 8'b00000001};
      8'h6F: r = '{len: 4'd3, dah: 8'b00000111};
      8'hF6: r = '{len: 4'd4, dah: 8'b00000111};
      8'h70: r = '{len: 4'd4, dah: 8'b00000110};
      8'h71: r = '{len: 4'd4, dah: 8'b00001011};
      8'h72: r = '{len: 4'd3, dah: 8'b00000010};
      8'h73: r = '{len: 4'd3, dah: 8'b00000000};
      8'h74: r = '{len: 4'd1, dah: 8'b00000001};
      8'h75: r = '{len: 4'd3, dah: 8'b00000100};
      8'hFC: r = '{len: 4'd4, dah: 8'b00001100};
      8'h76: r = '{len: 4'd4, dah: 8'b00001000};
      8'h77: r = '{len: 4'd3, dah: 8'b00000110};
      8'h78: r = '{len: 4'd4, dah: 8'b00001001};
      8'h79: r = '{len: 4'd4, dah: 8'b00001101};
      8'h7A: r = '{len: 4'd4, dah: 8'b00000011};
      8'h30: r = '{len: 4'd5, dah: 8'b00011111};
      8'h31: r = '{len: 4'd5, dah: 8'b00011110};
      8'h32: r = '{len: 4'd5, dah: 8'b00011100};
      8'h33: r = '{len: 4'd5, dah: 8'b00011000};
      8'h34: r = '{len: 4'd5, dah: 8'b00010000};
      8'h35: r = '{len: 4'd5, dah: 8'b00000000};
      8'h36: r = '{len: 4'd5, dah: 8'b00000001};
      8'h37: r = '{len: 4'd5, dah: 8'b00000011};
      8'h38: r = '{len: 4'd5, dah: 8'b00000111};
      8'h39: r = '{len: 4'd5, dah: 8'b00001111};
      8'h2C: r = '{len: 4'd6, dah: 8'b00110011};
      8'h21: r = '{len: 4'd6, dah: 8'b00110101};
      8'h3F: r = '{len: 4'd6, dah: 8'b00001100};
      8'h2E: r = '{len: 4'd6, dah: 8'b00101010};
      8'hE8: r = '{len: 4'd5, dah: 8'b00010010};
      8'hE9: r = '{len: 4'd5, dah: 8'b00000100};
      8'hDF: r = '{len: 4'd7, dah: 8'b00011000};
      8'h3A: r = '{len: 4'd6, dah: 8'b00000111};
      8'h3B: r = '{len: 4'd6, dah: 8'b00010101};
      8'h2D: r = '{len: 4'd6, dah: 8'b00100001};
      8'h5F: r = '{len: 4'd6, dah: 8'b00101100};
      8'h28: r = '{len: 4'd5, dah: 8'b00001101};
      8'h29: r = '{len: 4'd6, dah: 8'b00101101};
      8'h27: r = '{len: 4'd6, dah: 8'b00011110};
      8'h3D: r = '{len: 4'd5, dah: 8'b00010001};
      8'h2B: r = '{len: 4'd5, dah: 8'b00001010};
      8'h2F: r = '{len: 4'd5, dah: 8'b00001001};
      8'h40: r = '{len: 4'd6, dah: 8'b00010110};
      8'h22: r = '{len: 4'd6, dah: 8'b00010010};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/mck_regs.sv
module mck_regs
  import mck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [7:0]  mark_pins_q;
  logic [7:0]  space_pins_q;
  logic [15:0] unit_ms_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_pins_q  <= MARK_PINS_RST;
      space_pins_q <= SPACE_PINS_RST;
      unit_ms_q    <= UNIT_MS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MARK_PINS:  mark_pins_q  <= pwdata[7:0];
        REG_SPACE_PINS: space_pins_q <= pwdata[7:0];
        REG_UNIT_MS:    unit_ms_q    <= pwdata[15:0];
        default:        ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      REG_MARK_PINS:  prdata = {24'd0, mark_pins_q};
      REG_SPACE_PINS: prdata = {24'd0, space_pins_q};
      REG_UNIT_MS:    prdata = {16'd0, unit_ms_q};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{mark_pins: mark_pins_q, space_pins: space_pins_q, unit_ms: unit_ms_q};

endmodule

### sv/mck_dp.sv
module mck_dp
  import mck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  char_code_i,
  input  logic        final_char_i,
  input  cfg_t        cfg_i,
  input  mck_cmd_t    cmd_i,
  output mck_status_t status_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] pin_value, [8] is_mark, [11:9] length_units, [30:12] length_ms, [31] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  `include "morse_code_keyer_macros.svh"

  // Character held for the run.
  logic [MAX_ELEMENTS-1:0] dah_q;
  logic [LEN_W-1:0]        len_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    is_space_q;
  logic                    final_q;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  pin_q;
  logic        mark_q;
  logic [2:0]  units_q;
  logic [18:0] ms_q;
  logic        run_end_q;

  logic [7:0]  folded;
  morse_code_t code;
  logic [LEN_W-1:0] code_len;

  // Fold ASCII upper case, look the character up and cut long codes.
  always_comb begin
    folded = char_code_i;
    if (char_code_i >= CHAR_UPPER_A && char_code_i <= CHAR_UPPER_Z) begin
      folded = char_code_i + CASE_OFFSET;
    end
    code = mck_lookup(folded);
    if (code.len > 4'(MAX_ELEMENTS)) begin
      code_len = LEN_W'(MAX_ELEMENTS);
    end else begin
      code_len = code.len[LEN_W-1:0];
    end
  end

  // Character registers and element index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dah_q      <= code.dah[MAX_ELEMENTS-1:0];
      len_q      <= code_len;
      idx_q      <= '0;
      is_space_q <= (folded == CHAR_SPACE);
      final_q    <= final_char_i;
    end else if (cmd_i.advance) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Segment payload, length in milliseconds from a 3 by 16 bit product.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pin_q     <= cmd_i.mark ? cfg_i.mark_pins : cfg_i.space_pins;
      mark_q    <= cmd_i.mark;
      units_q   <= cmd_i.units;
      ms_q      <= 19'(cmd_i.units) * 19'(cfg_i.unit_ms);
      run_end_q <= cmd_i.run_end;
    end
  end

  assign status_o = '{
    is_space:   is_space_q,
    known:      (len_q != '0),
    elem_last:  ((LEN_W'(idx_q) + LEN_W'(1)) == len_q),
    dah:        dah_q[idx_q],
    final_char: final_q,
    out_free:   (!out_valid_q || m_axis_tready_i)
  };

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, ms_q, units_q, mark_q, pin_q};
  assign m_axis_tlast_o  = run_end_q;

  `MCK_ASSERT_IMP(a_emit_into_free, cmd_i.emit, status_o.out_free, "segment overwrote a held one")
  `MCK_ASSERT_NXT(a_emit_shows, cmd_i.emit, out_valid_q, "emitted segment not offered")
  `MCK_ASSERT_NXT(a_hold_stalled, out_valid_q && !m_axis_tready_i,
                  out_valid_q && $stable(m_axis_tdata_o), "stalled segment changed")

endmodule

### sv/mck_ctrl.sv
module mck_ctrl
  import mck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  mck_status_t status_i,
  output mck_cmd_t    cmd_o
);

  `include "morse_code_keyer_macros.svh"

  mck_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands; a segment goes out only when the output slot is free.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.is_space) begin
          state_d = ST_WORD_GAP;
        end else if (status_i.known) begin
          state_d = ST_MARK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MARK: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.mark    = 1'b1;
          cmd_o.units   = status_i.dah ? UNITS_DAH : UNITS_DIT;
          cmd_o.advance = 1'b1;
          if (status_i.elem_last) begin
            cmd_o.run_end = status_i.final_char;
            state_d       = status_i.final_char ? ST_IDLE : ST_CHAR_GAP;
          end else begin
            state_d = ST_ELEM_GAP;
          end
        end
      end
      ST_ELEM_GAP: begin
        if (status_i.out_free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.units = UNITS_ELEM_GAP;
          state_d     = ST_MARK;
        end
      end
      ST_WORD_GAP: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.units   = UNITS_WORD_GAP;
          cmd_o.run_end = status_i.final_char;
          state_d       = status_i.final_char ? ST_IDLE : ST_CHAR_GAP;
        end
      end
      ST_CHAR_GAP: begin
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.units   = UNITS_CHAR_GAP;
          cmd_o.run_end = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `MCK_ASSERT_NXT(a_accept_decodes, s_axis_tvalid_i && s_axis_tready_o, state_q == ST_DECODE,
                  "accepted character not decoded")
  `MCK_ASSERT_NXT(a_mark_then_gap, state_q == ST_MARK && cmd_o.emit && !status_i.elem_last,
                  state_q == ST_ELEM_GAP, "no gap between elements")
  `MCK_ASSERT_IMP(a_end_leaves, cmd_o.emit && cmd_o.run_end, state_d == ST_IDLE,
                  "run ended but controller stays busy")

endmodule

### sv/morse_code_keyer.sv
// Channel      | Direction | Payload
// s_axis       | in        | tdata[7:0] char_code, tlast final_char
// m_axis       | out       | tdata pin_value/is_mark/length_units/length_ms, tlast run_end
// APB (psel..) | in/out    | mark_pins @0x0, space_pins @0x4, unit_ms @0x8
//
// A character is taken while the sequencer is idle and decoded in the next cycle, then
// its segments leave one per cycle while the output is free, from the single-issue
// sequencer in the controller. An unknown character is decoded and gives no segment.
// A stalled output holds the sequencer; no new character is taken until the
// run is issued. Reset is asynchronous and active low; registers return to
// mark_pins 1, space_pins 0, unit_ms 100.
module morse_code_keyer
  import mck_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_code
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] pin_value, [8] is_mark, [11:9] length_units, [30:12] length_ms, [31] zero
  output logic [31:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg;
  mck_cmd_t    cmd;
  mck_status_t status;

  // Configuration registers.
  mck_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Segment sequencer.
  mck_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  // Code lookup, element index and output register.
  mck_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_code_i     (s_axis_tdata_i),
    .final_char_i    (s_axis_tlast_i),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
